// ===== hdl/klfia_pkg.sv =====
`default_nettype none

package klfia_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 8;

  typedef logic [1:0] op_t;
  localparam op_t OP_GET     = 2'd0;
  localparam op_t OP_RESERVE = 2'd1;
  localparam op_t OP_RELEASE = 2'd2;
  localparam op_t OP_CLEAR   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST_CHK,
    S_DECIDE,
    S_IDSCAN,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/keyed_lowest_free_id_allocator_top.sv =====
// Keyed lowest-free id allocator.
//
// A table of ENTRIES slots maps 64-bit identity keys to dense 8-bit handles.
// Requests arrive on the input channel (in_valid/in_ready) as one transfer
// carrying op, identity_key, identity_present and handle_in. Each request
// produces exactly one response transfer on the output channel
// (out_valid/out_ready) carrying handle_out, was_present and status.
//
// The block handles one request at a time. A get, or a reserve or release with
// a present identity, scans the whole table through the key and handle
// memories, one slot per cycle. A get that allocates a new handle then walks
// the candidate handles from 0 upward, one per cycle, and stops at the first
// one no entry holds. Clear and a reserve or release with an empty identity
// skip the scan and go straight to the decision state.
//
// Reset empties the table at once through per-slot valid flip-flops, so no
// clearing pass is needed. The response sits in an output register; if the
// receiver stalls, the block still accepts the next request and works on it,
// but holds it in the response state until the previous result is taken.

`default_nettype none

module keyed_lowest_free_id_allocator_top
  import klfia_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          op,
  input  wire logic [KEY_W-1:0]    identity_key,
  input  wire logic                identity_present,
  input  wire logic [HANDLE_W-1:0] handle_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [HANDLE_W-1:0]      handle_out,
  output logic                     was_present,
  output logic [1:0]               status
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state, state_next;

  // Captured request.
  op_t                 op_q;
  logic [KEY_W-1:0]    key_q;
  logic                present_q;
  logic [HANDLE_W-1:0] hin_q;

  // Table storage. Valid bits are flip-flops; keys and handles live in memories.
  logic [ENTRIES-1:0]  entry_valid;
  logic [KEY_W-1:0]    mem_key [ENTRIES];
  logic [HANDLE_W-1:0] mem_id  [ENTRIES];
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_id;

  // Scan sequencer and results gathered while scanning.
  logic [IDX_W-1:0]    scan_idx;
  logic                chk_vld;
  logic [IDX_W-1:0]    chk_idx;
  logic                found;
  logic [IDX_W-1:0]    found_slot;
  logic [HANDLE_W-1:0] found_id;
  logic                free_found;
  logic [IDX_W-1:0]    free_slot;
  logic [ENTRIES-1:0]  used;
  logic [IDX_W-1:0]    cand;

  // Pending response.
  logic [HANDLE_W-1:0] res_h;
  logic                res_was;
  status_t             res_st;

  // Combinational controls.
  logic                in_fire;
  logic                id_hit;
  logic                id_small;
  logic                wr_id_en;
  logic                wr_key_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [HANDLE_W-1:0] wr_id_data;
  logic                resp_load;
  logic                needs_scan;

  assign in_fire   = in_valid && in_ready;
  assign id_hit    = !used[cand] || (cand == LAST_IDX);
  assign id_small  = {1'b0, rd_id} < (HANDLE_W + 1)'(ENTRIES);
  assign resp_load = (state == S_RESP) && (!out_valid || out_ready);
  assign needs_scan = (op == OP_GET) ||
                      (((op == OP_RESERVE) || (op == OP_RELEASE)) && identity_present);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = needs_scan ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = S_LAST_CHK;
        end
      end
      S_LAST_CHK: state_next = S_DECIDE;
      S_DECIDE: begin
        if ((op_q == OP_GET) && !found && free_found) begin
          state_next = S_IDSCAN;
        end else begin
          state_next = S_RESP;
        end
      end
      S_IDSCAN: begin
        if (id_hit) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output and memory-control logic.
  always_comb begin
    in_ready   = (state == S_IDLE);
    wr_id_en   = 1'b0;
    wr_key_en  = 1'b0;
    wr_addr    = found ? found_slot : free_slot;
    wr_id_data = hin_q;
    unique case (state)
      S_DECIDE: begin
        if ((op_q == OP_RESERVE) && present_q) begin
          wr_id_en  = found || free_found;
          wr_key_en = !found && free_found;
        end
      end
      S_IDSCAN: begin
        wr_id_en   = id_hit;
        wr_key_en  = id_hit;
        wr_id_data = HANDLE_W'(cand);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Key and handle memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      mem_key[wr_addr] <= key_q;
    end
    if (wr_id_en) begin
      mem_id[wr_addr] <= wr_id_data;
    end
    rd_key <= mem_key[scan_idx];
    rd_id  <= mem_id[scan_idx];
  end

  // Valid bits: set on a new entry, cleared by release or clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      if (wr_key_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (state == S_DECIDE) begin
        if (op_q == OP_CLEAR) begin
          entry_valid <= '0;
        end else if ((op_q == OP_RELEASE) && present_q && found) begin
          entry_valid[found_slot] <= 1'b0;
        end
      end
    end
  end

  // Scan control. The read issued for slot k is registered and is
  // checked while the next slot is being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_idx;
    if (in_fire) begin
      op_q       <= op;
      key_q      <= identity_key;
      present_q  <= identity_present;
      hin_q      <= handle_in;
      scan_idx   <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      used       <= '0;
      cand       <= '0;
    end else begin
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (chk_vld) begin
        if (entry_valid[chk_idx]) begin
          if (!found && (rd_key == key_q)) begin
            found      <= 1'b1;
            found_slot <= chk_idx;
            found_id   <= rd_id;
          end
          // Only handles below ENTRIES can ever be the lowest free one.
          if (id_small) begin
            used[rd_id[IDX_W-1:0]] <= 1'b1;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_slot  <= chk_idx;
        end
      end
      if ((state == S_IDSCAN) && !id_hit) begin
        cand <= cand + 1'b1;
      end
    end
  end

  // Response formation.
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      res_h   <= '0;
      res_was <= 1'b0;
      res_st  <= STATUS_OK;
      unique case (op_q)
        OP_GET: begin
          if (found) begin
            res_h   <= found_id;
            res_was <= 1'b1;
          end else if (!free_found) begin
            res_st <= STATUS_FULL;
          end
        end
        OP_RESERVE: begin
          res_h <= hin_q;
          if (!present_q) begin
            res_st <= STATUS_EMPTY;
          end else if (found) begin
            res_was <= 1'b1;
          end else if (!free_found) begin
            res_st <= STATUS_FULL;
          end
        end
        OP_RELEASE: begin
          if (!present_q) begin
            res_st <= STATUS_EMPTY;
          end else if (found) begin
            res_h   <= found_id;
            res_was <= 1'b1;
          end
        end
        OP_CLEAR: begin
        end
        default: begin
        end
      endcase
    end else if ((state == S_IDSCAN) && id_hit) begin
      res_h <= HANDLE_W'(cand);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      handle_out  <= res_h;
      was_present <= res_was;
      status      <= res_st;
    end
  end

  // The candidate walk only runs for a get of a new key with a free slot.
  a_idscan_cause: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDSCAN) |-> ((op_q == OP_GET) && !found && free_found))
    else $error("handle search entered without a free slot");

  // A clear leaves every slot empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DECIDE) && (op_q == OP_CLEAR)) |=> (entry_valid == '0))
    else $error("clear left a valid slot");

  // The sequencer takes one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request accepted while busy");

  // A new entry is written only into a slot that was empty.
  a_new_slot_empty: assert property (@(posedge clk) disable iff (rst)
    wr_key_en |-> !entry_valid[wr_addr])
    else $error("new key written over a valid slot");

  // An ignored request never reports a known key.
  a_empty_not_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_EMPTY)) |-> !was_present)
    else $error("ignored request flagged as present");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  import klfia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped here if the block hangs. The slowest correct run is
  // about 1800 requests, plus stalls on both sides.
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_CHUNKS = 5;
  localparam int CHUNK_ITEMS = 350;
  localparam int POOL_SIZE = 24;
  localparam int IDLE_PERCENT = 29;
  // A full table scan plus a full id scan, with margin.
  localparam int SETTLE_CYCLES = 4 * ENTRIES + 16;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic                present;
    logic [HANDLE_W-1:0] hin;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                was;
    status_t             status;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          op = OP_GET;
  logic [KEY_W-1:0]    identity_key = '0;
  logic                identity_present = 1'b0;
  logic [HANDLE_W-1:0] handle_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [HANDLE_W-1:0] handle_out;
  logic                was_present;
  logic [1:0]          status;

  keyed_lowest_free_id_allocator_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .identity_key     (identity_key),
    .identity_present (identity_present),
    .handle_in        (handle_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .handle_out       (handle_out),
    .was_present      (was_present),
    .status           (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the id table. Keys and ids are only read where the slot
  // is valid, so their contents before the first write do not matter.
  logic                tbl_valid [ENTRIES];
  logic [KEY_W-1:0]    tbl_key   [ENTRIES];
  logic [HANDLE_W-1:0] tbl_id    [ENTRIES];

  req_t  pending_reqs [$];
  resp_t expected_resp [$];
  req_t  cur_req;
  logic  steady_flow = 1'b0;
  int    mismatch_count = 0;
  int    cycle_count = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  function automatic int find_key(logic [KEY_W-1:0] k);
    for (int s = 0; s < ENTRIES; s++) begin
      if (tbl_valid[s] && tbl_key[s] == k) return s;
    end
    return -1;
  endfunction

  function automatic int find_free_slot();
    for (int s = 0; s < ENTRIES; s++) begin
      if (!tbl_valid[s]) return s;
    end
    return -1;
  endfunction

  // Computes the response to one request and applies its effect on the table.
  function automatic resp_t predict_response(req_t r);
    resp_t res;
    int    slot;
    logic  busy;
    res = '0;
    res.status = STATUS_OK;
    case (r.op)
      OP_GET: begin
        // The presence flag plays no part in a get; the key is used as given.
        slot = find_key(r.key);
        if (slot >= 0) begin
          res.handle = tbl_id[slot];
          res.was = 1'b1;
        end else begin
          slot = find_free_slot();
          if (slot < 0) begin
            res.status = STATUS_FULL;
          end else begin
            // Lowest id held by no valid entry; zero if all were taken.
            for (int cand = 0; cand < 256; cand++) begin
              busy = 1'b0;
              for (int s = 0; s < ENTRIES; s++) begin
                if (tbl_valid[s] && tbl_id[s] == HANDLE_W'(cand)) busy = 1'b1;
              end
              if (!busy) begin
                res.handle = HANDLE_W'(cand);
                break;
              end
            end
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = r.key;
            tbl_id[slot] = res.handle;
          end
        end
      end
      OP_RESERVE: begin
        res.handle = r.hin;
        if (!r.present) begin
          res.status = STATUS_EMPTY;
        end else begin
          slot = find_key(r.key);
          if (slot >= 0) begin
            res.was = 1'b1;
            tbl_id[slot] = r.hin;
          end else begin
            slot = find_free_slot();
            if (slot < 0) begin
              res.status = STATUS_FULL;
            end else begin
              // The id is stored even if another key already holds it.
              tbl_valid[slot] = 1'b1;
              tbl_key[slot] = r.key;
              tbl_id[slot] = r.hin;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (!r.present) begin
          res.status = STATUS_EMPTY;
        end else begin
          slot = find_key(r.key);
          if (slot >= 0) begin
            res.handle = tbl_id[slot];
            res.was = 1'b1;
            tbl_valid[slot] = 1'b0;
          end
        end
      end
      OP_CLEAR: begin
        for (int s = 0; s < ENTRIES; s++) tbl_valid[s] = 1'b0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(op_t o, logic [KEY_W-1:0] k, logic p,
                                    logic [HANDLE_W-1:0] h);
    req_t r;
    r.op = o;
    r.key = k;
    r.present = p;
    r.hin = h;
    return r;
  endfunction

  // Random requests draw most keys from a small pool so that hits, releases
  // of held keys and a full table are all common; a few keys are fresh.
  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 48) r.op = OP_GET;
    else if (pick < 68) r.op = OP_RESERVE;
    else if (pick < 98) r.op = OP_RELEASE;
    else r.op = OP_CLEAR;
    if ($urandom_range(9) == 0) r.key = {$urandom, $urandom};
    else r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    r.present = ($urandom_range(9) != 0);
    // Small ids collide with allocated ones and leave holes for the id scan.
    if ($urandom_range(1) == 0) r.hin = HANDLE_W'($urandom_range(19));
    else r.hin = HANDLE_W'($urandom_range(255));
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [KEY_W-1:0] got,
                                 logic [KEY_W-1:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Driver: a request stays on the bus until its transfer happens. The
  // expected response is worked out at the edge where the transfer occurs.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_resp.push_back(predict_response(cur_req));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          op <= cur_req.op;
          identity_key <= cur_req.key;
          identity_present <= cur_req.present;
          handle_in <= cur_req.hin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: back-pressure at random and compare every response transfer
  // against the oldest outstanding expectation.
  always @(posedge clk) begin
    resp_t want;
    out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    if (!rst && out_valid && out_ready) begin
      if (expected_resp.size() == 0) begin
        report_mismatch("unexpected response, handle_out", KEY_W'(handle_out), '0);
      end else begin
        want = expected_resp.pop_front();
        if (handle_out !== want.handle) begin
          report_mismatch("handle_out", KEY_W'(handle_out), KEY_W'(want.handle));
        end
        if (was_present !== want.was) begin
          report_mismatch("was_present", KEY_W'(was_present), KEY_W'(want.was));
        end
        if (status !== want.status) begin
          report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus: a directed pass over the corner cases, then random chunks. The
  // sender waits for every response between chunks, and one chunk runs with
  // no idling on either side.
  initial begin
    logic [KEY_W-1:0] ones;
    ones = '1;
    for (int s = 0; s < ENTRIES; s++) tbl_valid[s] = 1'b0;
    for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};

    // Clear of an empty table answers with all zeros.
    pending_reqs.push_back(make_req(OP_CLEAR, ones, 1'b1, '1));
    // A get ignores the presence flag: key zero with an empty identity is
    // allocated id zero.
    pending_reqs.push_back(make_req(OP_GET, '0, 1'b0, '1));
    pending_reqs.push_back(make_req(OP_GET, ones, 1'b1, '0));
    pending_reqs.push_back(make_req(OP_GET, '0, 1'b1, 8'h5a));
    // Reserve and release with an empty identity are ignored.
    pending_reqs.push_back(make_req(OP_RESERVE, ones, 1'b0, '1));
    pending_reqs.push_back(make_req(OP_RELEASE, ones, 1'b0, '1));
    // Release of a key that was never stored.
    pending_reqs.push_back(make_req(OP_RELEASE, 64'h0123_4567_89ab_cdef, 1'b1, '0));
    // Overwrite the id of a known key, then reserve an id another key holds.
    pending_reqs.push_back(make_req(OP_RESERVE, '0, 1'b1, '1));
    pending_reqs.push_back(make_req(OP_RESERVE, 64'hfedc_ba98_7654_3210, 1'b1, 8'd1));
    pending_reqs.push_back(make_req(OP_RELEASE, ones, 1'b1, '0));
    // Id one is still held through the shared reserve, so this gets id zero.
    pending_reqs.push_back(make_req(OP_GET, 64'h8000_0000_0000_0001, 1'b1, '0));
    // Fill the table, then try to add one more key by get and by reserve.
    for (int k = 0; k < ENTRIES - 3; k++) begin
      pending_reqs.push_back(make_req(OP_GET, 64'h5555_0000_0000_0000 + k, 1'b1, '0));
    end
    pending_reqs.push_back(make_req(OP_GET, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, '0));
    pending_reqs.push_back(make_req(OP_RESERVE, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 8'h80));
    pending_reqs.push_back(make_req(OP_CLEAR, '0, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int chunk = 0; chunk <= RANDOM_CHUNKS; chunk++) begin
      // Hold off until the block has answered everything sent so far.
      @(negedge clk);
      while (pending_reqs.size() != 0 || in_valid || expected_resp.size() != 0) begin
        @(negedge clk);
      end
      if (chunk < RANDOM_CHUNKS) begin
        steady_flow = (chunk == 2);
        for (int k = 0; k < CHUNK_ITEMS; k++) pending_reqs.push_back(random_req());
      end
    end

    steady_flow = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
